/* rtl/delta_list_sleep_queue_unit_assert.svh */
// Assertion macros for the delta-list sleep queue checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef DELTA_LIST_SLEEP_QUEUE_UNIT_ASSERT_SVH
`define DELTA_LIST_SLEEP_QUEUE_UNIT_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define DLSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition on one edge brings a consequence on the next.
`define DLSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error(msg);

`endif

/* rtl/dlsq_pkg.sv */
// Shared types, sizes and codes of the delta-list sleep queue.
// No dependencies; used by every module of the block.
package dlsq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdBits     = 8;
  localparam int unsigned TimeBits   = 16;
  localparam int unsigned MaxResults = 16;

  localparam int unsigned IdxW     = $clog2(QueueDepth);
  localparam int unsigned CntW     = $clog2(QueueDepth + 1);
  localparam int unsigned ResCntW  = $clog2(MaxResults + 1);
  localparam int unsigned InDataW  = ((IdBits + TimeBits + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((IdBits + 7) / 8) * 8;

  typedef logic [IdBits-1:0]   id_t;
  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [ResCntW-1:0]  res_cnt_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    EV_INSERTED  = 3'd0,
    EV_FULL      = 3'd1,
    EV_REMOVED   = 3'd2,
    EV_NOT_FOUND = 3'd3,
    EV_EXPIRED   = 3'd4,
    EV_TICK_NONE = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ST_NOP    = 2'd0,
    ST_WRITE  = 2'd1,
    ST_INSERT = 2'd2,
    ST_DROP   = 2'd3
  } store_op_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_DISPATCH = 4'd1,
    S_INS_WALK = 4'd2,
    S_INS_FIX  = 4'd3,
    S_INS_PUT  = 4'd4,
    S_RM_WALK  = 4'd5,
    S_RM_MERGE = 4'd6,
    S_RM_DROP  = 4'd7,
    S_TK_DEC   = 4'd8,
    S_TK_CHK   = 4'd9
  } state_e;

  typedef struct packed {
    store_op_e op;
    idx_t      idx;
    id_t       id;
    time_t     delta;
  } store_cmd_t;

  typedef struct packed {
    alu_op_e op;
    time_t   a;
    time_t   b;
  } alu_req_t;

  typedef struct packed {
    time_t y;
    logic  borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic   valid;
    event_e ev;
    id_t    id;
    logic   last;
  } result_t;

endpackage

/* rtl/dlsq_store.sv */
// Entry store of the sleep queue: ids and deltas with in-place shift up/down.
// Depends on dlsq_pkg.
module dlsq_store (
  input  logic                 clk_i,
  input  dlsq_pkg::store_cmd_t cmd_i,
  input  dlsq_pkg::idx_t       rd_idx_i,
  output dlsq_pkg::id_t        rd_id_o,
  output dlsq_pkg::time_t      rd_delta_o,
  output dlsq_pkg::time_t      second_delta_o
);

  dlsq_pkg::id_t   ids_q   [dlsq_pkg::QueueDepth];
  dlsq_pkg::time_t deltas_q[dlsq_pkg::QueueDepth];

  for (genvar g = 0; g < dlsq_pkg::QueueDepth; g++) begin : g_entry
    dlsq_pkg::id_t   below_id, above_id;
    dlsq_pkg::time_t below_d, above_d;

    if (g > 0) begin : g_below
      assign below_id = ids_q[g-1];
      assign below_d  = deltas_q[g-1];
    end else begin : g_bottom
      assign below_id = ids_q[g];
      assign below_d  = deltas_q[g];
    end

    if (g < dlsq_pkg::QueueDepth - 1) begin : g_above
      assign above_id = ids_q[g+1];
      assign above_d  = deltas_q[g+1];
    end else begin : g_top
      assign above_id = ids_q[g];
      assign above_d  = deltas_q[g];
    end

    always_ff @(posedge clk_i) begin
      unique case (cmd_i.op)
        dlsq_pkg::ST_NOP: begin
        end
        dlsq_pkg::ST_WRITE: begin
          if (cmd_i.idx == dlsq_pkg::IdxW'(g)) begin
            deltas_q[g] <= cmd_i.delta;
          end
        end
        dlsq_pkg::ST_INSERT: begin
          if (cmd_i.idx == dlsq_pkg::IdxW'(g)) begin
            ids_q[g]    <= cmd_i.id;
            deltas_q[g] <= cmd_i.delta;
          end else if (cmd_i.idx < dlsq_pkg::IdxW'(g)) begin
            ids_q[g]    <= below_id;
            deltas_q[g] <= below_d;
          end
        end
        dlsq_pkg::ST_DROP: begin
          if (cmd_i.idx <= dlsq_pkg::IdxW'(g)) begin
            ids_q[g]    <= above_id;
            deltas_q[g] <= above_d;
          end
        end
      endcase
    end
  end

  assign rd_id_o        = ids_q[rd_idx_i];
  assign rd_delta_o     = deltas_q[rd_idx_i];
  assign second_delta_o = deltas_q[1];

endmodule

/* rtl/dlsq_alu.sv */
// Shared add/subtract unit of the sleep queue; borrow doubles as compare.
// Depends on dlsq_pkg.
module dlsq_alu (
  input  dlsq_pkg::alu_req_t req_i,
  output dlsq_pkg::alu_rsp_t rsp_o
);

  logic [dlsq_pkg::TimeBits:0] ext;

  always_comb begin
    unique case (req_i.op)
      dlsq_pkg::ALU_ADD: ext = {1'b0, req_i.a} + {1'b0, req_i.b};
      dlsq_pkg::ALU_SUB: ext = {1'b0, req_i.a} - {1'b0, req_i.b};
    endcase
  end

  assign rsp_o.y      = ext[dlsq_pkg::TimeBits-1:0];
  assign rsp_o.borrow = (req_i.op == dlsq_pkg::ALU_SUB) & ext[dlsq_pkg::TimeBits];

endmodule

/* rtl/dlsq_ctrl.sv */
// Sequencer of the sleep queue: walks entries one per cycle through the shared ALU.
// Depends on dlsq_pkg; drives dlsq_store and dlsq_alu.
module dlsq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_kind_i,
  input  dlsq_pkg::id_t        in_id_i,
  input  dlsq_pkg::time_t      in_timeout_i,
  output dlsq_pkg::idx_t       rd_idx_o,
  input  dlsq_pkg::id_t        rd_id_i,
  input  dlsq_pkg::time_t      rd_delta_i,
  input  dlsq_pkg::time_t      second_delta_i,
  output dlsq_pkg::store_cmd_t cmd_o,
  output dlsq_pkg::alu_req_t   alu_req_o,
  input  dlsq_pkg::alu_rsp_t   alu_rsp_i,
  input  logic                 slot_free_i,
  output dlsq_pkg::result_t    result_o
);

  dlsq_pkg::state_e   state_q, state_d;
  dlsq_pkg::kind_e    kind_q, kind_d;
  dlsq_pkg::id_t      id_q, id_d;
  dlsq_pkg::time_t    t_q, t_d;
  dlsq_pkg::time_t    held_q, held_d;
  dlsq_pkg::cnt_t     pos_q, pos_d;
  dlsq_pkg::cnt_t     count_q, count_d;
  dlsq_pkg::res_cnt_t n_q, n_d;

  dlsq_pkg::cnt_t pos_inc;
  logic           in_list;
  logic           head_zero;
  logic           more;

  assign pos_inc   = pos_q + dlsq_pkg::CntW'(1);
  assign in_list   = pos_q < count_q;
  assign head_zero = rd_delta_i == '0;
  assign more      = (count_q > dlsq_pkg::CntW'(1)) && (second_delta_i == '0) &&
                     ((n_q + dlsq_pkg::ResCntW'(1)) < dlsq_pkg::ResCntW'(dlsq_pkg::MaxResults));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlsq_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    id_q   <= id_d;
    t_q    <= t_d;
    held_q <= held_d;
    pos_q  <= pos_d;
    n_q    <= n_d;
  end

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    id_d      = id_q;
    t_d       = t_q;
    held_d    = held_q;
    pos_d     = pos_q;
    count_d   = count_q;
    n_d       = n_q;
    in_ready_o = 1'b0;
    rd_idx_o  = pos_q[dlsq_pkg::IdxW-1:0];
    cmd_o     = '{op: dlsq_pkg::ST_NOP, idx: pos_q[dlsq_pkg::IdxW-1:0], id: id_q, delta: t_q};
    alu_req_o = '{op: dlsq_pkg::ALU_SUB, a: t_q, b: rd_delta_i};
    result_o  = '{valid: 1'b0, ev: dlsq_pkg::EV_INSERTED, id: id_q, last: 1'b1};

    unique case (state_q)
      dlsq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d  = dlsq_pkg::kind_e'(in_kind_i);
          id_d    = in_id_i;
          t_d     = (in_timeout_i == '0) ? dlsq_pkg::TimeBits'(1) : in_timeout_i;
          pos_d   = '0;
          n_d     = '0;
          state_d = dlsq_pkg::S_DISPATCH;
        end
      end

      dlsq_pkg::S_DISPATCH: begin
        unique case (kind_q)
          dlsq_pkg::KIND_INSERT: begin
            if (count_q == dlsq_pkg::CntW'(dlsq_pkg::QueueDepth)) begin
              if (slot_free_i) begin
                result_o.valid = 1'b1;
                result_o.ev    = dlsq_pkg::EV_FULL;
                state_d        = dlsq_pkg::S_IDLE;
              end
            end else begin
              state_d = dlsq_pkg::S_INS_WALK;
            end
          end
          dlsq_pkg::KIND_REMOVE: state_d = dlsq_pkg::S_RM_WALK;
          dlsq_pkg::KIND_TICK:   state_d = dlsq_pkg::S_TK_DEC;
          default:               state_d = dlsq_pkg::S_IDLE;
        endcase
      end

      // Subtract each wait ahead while the remaining time still covers it.
      dlsq_pkg::S_INS_WALK: begin
        if (in_list && !alu_rsp_i.borrow) begin
          t_d   = alu_rsp_i.y;
          pos_d = pos_inc;
        end else if (in_list) begin
          state_d = dlsq_pkg::S_INS_FIX;
        end else begin
          state_d = dlsq_pkg::S_INS_PUT;
        end
      end

      // Shorten the follower by the new entry's delta.
      dlsq_pkg::S_INS_FIX: begin
        alu_req_o = '{op: dlsq_pkg::ALU_SUB, a: rd_delta_i, b: t_q};
        cmd_o.op    = dlsq_pkg::ST_WRITE;
        cmd_o.delta = alu_rsp_i.y;
        state_d     = dlsq_pkg::S_INS_PUT;
      end

      dlsq_pkg::S_INS_PUT: begin
        if (slot_free_i) begin
          cmd_o.op       = dlsq_pkg::ST_INSERT;
          count_d        = count_q + dlsq_pkg::CntW'(1);
          result_o.valid = 1'b1;
          result_o.ev    = dlsq_pkg::EV_INSERTED;
          state_d        = dlsq_pkg::S_IDLE;
        end
      end

      dlsq_pkg::S_RM_WALK: begin
        if (!in_list) begin
          if (slot_free_i) begin
            result_o.valid = 1'b1;
            result_o.ev    = dlsq_pkg::EV_NOT_FOUND;
            state_d        = dlsq_pkg::S_IDLE;
          end
        end else if (rd_id_i == id_q) begin
          held_d  = rd_delta_i;
          state_d = dlsq_pkg::S_RM_MERGE;
        end else begin
          pos_d = pos_inc;
        end
      end

      // Fold the removed delta into the entry behind it.
      dlsq_pkg::S_RM_MERGE: begin
        rd_idx_o  = pos_inc[dlsq_pkg::IdxW-1:0];
        alu_req_o = '{op: dlsq_pkg::ALU_ADD, a: rd_delta_i, b: held_q};
        if (pos_inc < count_q) begin
          cmd_o.op    = dlsq_pkg::ST_WRITE;
          cmd_o.idx   = pos_inc[dlsq_pkg::IdxW-1:0];
          cmd_o.delta = alu_rsp_i.y;
        end
        state_d = dlsq_pkg::S_RM_DROP;
      end

      dlsq_pkg::S_RM_DROP: begin
        if (slot_free_i) begin
          cmd_o.op       = dlsq_pkg::ST_DROP;
          count_d        = count_q - dlsq_pkg::CntW'(1);
          result_o.valid = 1'b1;
          result_o.ev    = dlsq_pkg::EV_REMOVED;
          state_d        = dlsq_pkg::S_IDLE;
        end
      end

      // Decrement the head, saturating at zero.
      dlsq_pkg::S_TK_DEC: begin
        rd_idx_o = '0;
        if (count_q == '0) begin
          if (slot_free_i) begin
            result_o.valid = 1'b1;
            result_o.ev    = dlsq_pkg::EV_TICK_NONE;
            result_o.id    = '0;
            state_d        = dlsq_pkg::S_IDLE;
          end
        end else begin
          alu_req_o   = '{op: dlsq_pkg::ALU_SUB, a: rd_delta_i, b: dlsq_pkg::TimeBits'(1)};
          cmd_o.op    = dlsq_pkg::ST_WRITE;
          cmd_o.idx   = '0;
          cmd_o.delta = alu_rsp_i.borrow ? '0 : alu_rsp_i.y;
          state_d     = dlsq_pkg::S_TK_CHK;
        end
      end

      // Expire the head while it is due; peek at entry one to mark the last beat.
      dlsq_pkg::S_TK_CHK: begin
        rd_idx_o = '0;
        if (slot_free_i) begin
          result_o.valid = 1'b1;
          if ((count_q != '0) && head_zero &&
              (n_q < dlsq_pkg::ResCntW'(dlsq_pkg::MaxResults))) begin
            cmd_o.op     = dlsq_pkg::ST_DROP;
            cmd_o.idx    = '0;
            count_d      = count_q - dlsq_pkg::CntW'(1);
            n_d          = n_q + dlsq_pkg::ResCntW'(1);
            result_o.ev  = dlsq_pkg::EV_EXPIRED;
            result_o.id  = rd_id_i;
            result_o.last = !more;
            if (!more) begin
              state_d = dlsq_pkg::S_IDLE;
            end
          end else begin
            result_o.ev = dlsq_pkg::EV_TICK_NONE;
            result_o.id = '0;
            state_d     = dlsq_pkg::S_IDLE;
          end
        end
      end

      default: state_d = dlsq_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/delta_list_sleep_queue_unit.sv */
// Delta-list sleep queue, one beat at a time. Steps from the accepting edge: insert walks the entries
// whose waits it covers, shortens the follower if there is one, then puts; remove walks past other ids,
// folds the delta into the follower and drops; a missing id walks the whole list; tick decrements the
// head, then expires one due entry per result. A new beat is taken only once the sequencer is back in
// idle after the last result loads; walks go one entry per cycle through the shared add/subtract unit.
// Reset (rst_ni low, asynchronous): queue empty, sequencer idle, no result pending; entries kept.
module delta_list_sleep_queue_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dlsq_pkg::InDataW-1:0]  s_axis_tdata,   // task_id [7:0], timeout [23:8]
  input  logic [1:0]                    s_axis_tuser,   // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dlsq_pkg::OutDataW-1:0] m_axis_tdata,   // task_id_out [7:0]
  output logic [2:0]                    m_axis_tuser,   // event_res
  output logic                          m_axis_tlast    // last
);

  dlsq_pkg::store_cmd_t cmd;
  dlsq_pkg::alu_req_t   alu_req;
  dlsq_pkg::alu_rsp_t   alu_rsp;
  dlsq_pkg::result_t    result;
  dlsq_pkg::idx_t       rd_idx;
  dlsq_pkg::id_t        rd_id;
  dlsq_pkg::time_t      rd_delta;
  dlsq_pkg::time_t      second_delta;

  // Output register: one result beat held until the sink takes it.
  logic             out_valid_q;
  dlsq_pkg::event_e out_ev_q;
  dlsq_pkg::id_t    out_id_q;
  logic             out_last_q;
  logic             slot_free;

  // The sequencer may load a new result when the slot is empty or drains this cycle.
  assign slot_free = !out_valid_q || m_axis_tready;

  dlsq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_kind_i      (s_axis_tuser),
    .in_id_i        (s_axis_tdata[dlsq_pkg::IdBits-1:0]),
    .in_timeout_i   (s_axis_tdata[dlsq_pkg::IdBits +: dlsq_pkg::TimeBits]),
    .rd_idx_o       (rd_idx),
    .rd_id_i        (rd_id),
    .rd_delta_i     (rd_delta),
    .second_delta_i (second_delta),
    .cmd_o          (cmd),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp),
    .slot_free_i    (slot_free),
    .result_o       (result)
  );

  dlsq_store u_store (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .rd_idx_i       (rd_idx),
    .rd_id_o        (rd_id),
    .rd_delta_o     (rd_delta),
    .second_delta_o (second_delta)
  );

  dlsq_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Hold the beat while stalled; load a fresh one, or drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      out_ev_q   <= result.ev;
      out_id_q   <= result.id;
      out_last_q <= result.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = dlsq_pkg::OutDataW'(out_id_q);
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/dlsq_checker.sv */
// Port-level checker for the delta-list sleep queue, bound to the top level.
// Depends on dlsq_pkg and delta_list_sleep_queue_unit_assert.svh.
`include "delta_list_sleep_queue_unit_assert.svh"

module dlsq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dlsq_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [2:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  logic in_beat;
  logic out_stall;
  logic out_single;
  logic out_none;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_single = m_axis_tvalid && (m_axis_tuser != dlsq_pkg::EV_EXPIRED);
  assign out_none   = m_axis_tvalid && (m_axis_tuser == dlsq_pkg::EV_TICK_NONE);

  // A taken beat keeps the block busy for at least the next cycle.
  `DLSQ_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_axis_tready, "ready stayed high after a beat")

  // Only expiries may be followed by more results of the same beat.
  `DLSQ_ASSERT(a_single_is_last, out_single |-> m_axis_tlast, "non-expiry result without last")

  // A tick that expires nothing names no task.
  `DLSQ_ASSERT(a_none_id_zero, out_none |-> m_axis_tdata == '0, "tick-none result with nonzero id")

  // A stalled result beat stays up.
  `DLSQ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result beat dropped while stalled")

endmodule

bind delta_list_sleep_queue_unit dlsq_checker u_dlsq_checker (.*);
